/* sv/dcdq_pkg.sv */
// Shared types, constants and fixed-point helpers for the droop dq inverter controller.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package dcdq_pkg;

   localparam logic [15:0] PKG_PWM_PERIOD_COUNT = 16'd2500;
   localparam logic [31:0] PKG_OMEGA_NOM_Q16    = 32'd24706225;
   localparam logic [31:0] PKG_VOLT_NOM_Q16     = 32'd1638400;
   localparam logic [31:0] PKG_IND_FF_Q16       = 32'd66;
   localparam logic [31:0] PKG_OUT_CUR_FF_Q16   = 32'd65536;

   localparam logic signed [32:0] SIN_A     = 33'sd102944;
   localparam logic signed [32:0] SIN_B     = 33'sd42047;
   localparam logic signed [32:0] SIN_C     = 33'sd4640;
   localparam logic signed [32:0] SQRT3_Q16 = 33'sd113512;
   localparam logic signed [31:0] ONE_Q16   = 32'sd65536;

   localparam int unsigned LAST_STEP = 41;
   localparam int unsigned STEP_W    = 6;

   // register indexes of the configuration port
   localparam logic [2:0] CSR_DROOP_P = 3'd0;
   localparam logic [2:0] CSR_DROOP_Q = 3'd1;
   localparam logic [2:0] CSR_KP_V    = 3'd2;
   localparam logic [2:0] CSR_KI_V_DT = 3'd3;
   localparam logic [2:0] CSR_KP_I    = 3'd4;
   localparam logic [2:0] CSR_KI_I_DT = 3'd5;
   localparam logic [2:0] CSR_CUR_LIM = 3'd6;
   localparam logic [2:0] CSR_FCAP    = 3'd7;

   typedef enum logic [1:0] {PH_A, PH_B, PH_C} phase_type;

   typedef struct packed {
      logic              capture;
      logic              step_en;
      logic [STEP_W-1:0] step;
      logic              div_start;
      phase_type         phase;
      logic              load_out;
   } cmd_type;

   typedef struct packed {
      logic div_done;
   } status_type;

   // saturate a 34-bit sum to the signed 32-bit range
   function automatic logic signed [31:0] sat34(input logic signed [33:0] x);
      logic signed [31:0] r;
      if (x > 34'sd2147483647) r = 32'sh7FFF_FFFF;
      else if (x < -34'sd2147483648) r = 32'sh8000_0000;
      else r = x[31:0];
      return r;
   endfunction

   // Q16.16 product: floor shift by 16, then saturate
   function automatic logic signed [31:0] sat_prod(input logic signed [65:0] p);
      logic signed [49:0] sh;
      logic signed [31:0] r;
      sh = p[65:16];
      if (sh > 50'sd2147483647) r = 32'sh7FFF_FFFF;
      else if (sh < -50'sd2147483648) r = 32'sh8000_0000;
      else r = sh[31:0];
      return r;
   endfunction

   function automatic logic signed [32:0] sx33(input logic signed [31:0] x);
      return {x[31], x};
   endfunction

   function automatic logic signed [32:0] neg33(input logic signed [31:0] x);
      return -{x[31], x};
   endfunction

   function automatic logic signed [31:0] sadd(input logic signed [32:0] a,
                                               input logic signed [32:0] b);
      logic signed [33:0] s;
      s = {a[32], a} + {b[32], b};
      return sat34(s);
   endfunction

   // position inside the quadrant, Q16
   function automatic logic signed [32:0] sin_z(input logic [15:0] ang);
      logic [16:0] zr;
      zr = {1'b0, ang[13:0], 2'b00};
      if (ang[14]) zr = 17'd65536 - zr;
      return {16'd0, zr};
   endfunction

   function automatic logic signed [31:0] sin_cap(input logic signed [31:0] t,
                                                  input logic neg);
      logic signed [31:0] r;
      r = (t > ONE_Q16) ? ONE_Q16 : t;
      return neg ? -r : r;
   endfunction

endpackage
`default_nettype wire

/* sv/droop_cascaded_dq_inverter_control.sv */
// Droop inverter controller with cascaded dq PI loops, one request at a time.
// Sequence: 42 microsteps on the shared 33x33 multiplier, then per phase one
// multiply and a 17-step restoring divide (skipped when the duty saturates or vdc is
// zero), then the result load. The next request is taken the cycle after the result
// is parked.
// Reset (synchronous, active high) zeroes config registers and integrators.
`timescale 1ns / 1ps
`default_nettype none
module droop_cascaded_dq_inverter_control
   import dcdq_pkg::*;
#(
   parameter logic [15:0] PWM_PERIOD_COUNT = PKG_PWM_PERIOD_COUNT,
   parameter logic [31:0] OMEGA_NOM_Q16    = PKG_OMEGA_NOM_Q16,
   parameter logic [31:0] VOLT_NOM_Q16     = PKG_VOLT_NOM_Q16,
   parameter logic [31:0] IND_FF_Q16       = PKG_IND_FF_Q16,
   parameter logic [31:0] OUT_CUR_FF_Q16   = PKG_OUT_CUR_FF_Q16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_wr_en,
   input  wire logic [2:0]         csr_index,
   input  wire logic [30:0]        csr_wdata,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic               req_enable,
   input  wire logic signed [31:0] req_p_meas,
   input  wire logic signed [31:0] req_q_meas,
   input  wire logic signed [31:0] req_vc_d,
   input  wire logic signed [31:0] req_vc_q,
   input  wire logic signed [31:0] req_io_d,
   input  wire logic signed [31:0] req_io_q,
   input  wire logic signed [31:0] req_il_d,
   input  wire logic signed [31:0] req_il_q,
   input  wire logic [15:0]        req_theta,
   input  wire logic [30:0]        req_vdc,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [15:0]             rsp_duty_a,
   output logic [15:0]             rsp_duty_b,
   output logic [15:0]             rsp_duty_c,
   output logic signed [31:0]      rsp_omega_out,
   output logic signed [31:0]      rsp_vref_d,
   output logic signed [31:0]      rsp_iref_d,
   output logic signed [31:0]      rsp_iref_q,
   output logic signed [31:0]      rsp_vinv_d,
   output logic signed [31:0]      rsp_vinv_q
);

   cmd_type    cmd;
   status_type status;

   dcdq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   dcdq_datapath #(
      .PWM_PERIOD_COUNT (PWM_PERIOD_COUNT),
      .OMEGA_NOM_Q16    (OMEGA_NOM_Q16),
      .VOLT_NOM_Q16     (VOLT_NOM_Q16),
      .IND_FF_Q16       (IND_FF_Q16),
      .OUT_CUR_FF_Q16   (OUT_CUR_FF_Q16)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_enable    (req_enable),
      .req_p_meas    (req_p_meas),
      .req_q_meas    (req_q_meas),
      .req_vc_d      (req_vc_d),
      .req_vc_q      (req_vc_q),
      .req_io_d      (req_io_d),
      .req_io_q      (req_io_q),
      .req_il_d      (req_il_d),
      .req_il_q      (req_il_q),
      .req_theta     (req_theta),
      .req_vdc       (req_vdc),
      .rsp_duty_a    (rsp_duty_a),
      .rsp_duty_b    (rsp_duty_b),
      .rsp_duty_c    (rsp_duty_c),
      .rsp_omega_out (rsp_omega_out),
      .rsp_vref_d    (rsp_vref_d),
      .rsp_iref_d    (rsp_iref_d),
      .rsp_iref_q    (rsp_iref_q),
      .rsp_vinv_d    (rsp_vinv_d),
      .rsp_vinv_q    (rsp_vinv_q)
   );

endmodule
`default_nettype wire

/* sv/dcdq_ctrl.sv */
// Sequencer for the droop dq controller: request intake, microstep count,
// duty division per phase and result hand-off. Uses dcdq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module dcdq_ctrl
   import dcdq_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   input  wire status_type status,
   output cmd_type         cmd
);

   typedef enum logic [2:0] {S_IDLE, S_RUN, S_DSTART, S_DWAIT, S_FIN} state_type;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   phase_type         phase_ff, phase_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              load;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      phase_in = phase_ff;
      load     = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_RUN;
               step_in  = '0;
            end
         end
         S_RUN: begin
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(LAST_STEP)) begin
               state_in = S_DSTART;
               phase_in = PH_A;
            end
         end
         S_DSTART: state_in = S_DWAIT;
         S_DWAIT: begin
            if (status.div_done) begin
               case (phase_ff)
                  PH_A:    begin phase_in = PH_B; state_in = S_DSTART; end
                  PH_B:    begin phase_in = PH_C; state_in = S_DSTART; end
                  default: state_in = S_FIN;
               endcase
            end
         end
         S_FIN: begin
            // result slot must be free before it is overwritten
            if (!rsp_valid_ff || rsp_ready) begin
               load     = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      rsp_valid_in = load | (rsp_valid_ff & ~rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         phase_ff     <= PH_A;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready     = (state_ff == S_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign cmd.capture   = req_ready & req_valid;
   assign cmd.step_en   = (state_ff == S_RUN);
   assign cmd.step      = step_ff;
   assign cmd.div_start = (state_ff == S_DSTART);
   assign cmd.phase     = phase_ff;
   assign cmd.load_out  = load;

endmodule
`default_nettype wire

/* sv/dcdq_duty.sv */
// Duty count unit: one multiply, then a restoring divider, one quotient bit per cycle.
// Uses dcdq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module dcdq_duty
   import dcdq_pkg::*;
#(
   parameter logic [15:0] PWM_PERIOD_COUNT = PKG_PWM_PERIOD_COUNT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic signed [31:0] abc,
   input  wire logic [30:0]        vdc,
   output logic                    done,
   output logic [15:0]             duty
);

   typedef enum logic [1:0] {D_IDLE, D_CHK, D_DIV, D_FIN} dstate_type;

   dstate_type         dstate_ff;
   logic signed [50:0] num_ff;
   logic [49:0]        rem_ff;
   logic [49:0]        dsh_ff;
   logic [31:0]        den_ff;
   logic [16:0]        quo_ff;
   logic [4:0]         cnt_ff;
   logic               vz_ff, pos_ff, neg_ff;
   logic               done_ff;
   logic [15:0]        duty_ff;
   logic signed [33:0] sum;
   logic signed [50:0] prod;

   assign sum  = {abc[31], abc, 1'b0} + $signed({3'b000, vdc});
   assign prod = sum * $signed({1'b0, PWM_PERIOD_COUNT});

   always_ff @(posedge clock) begin
      if (reset) begin
         dstate_ff <= D_IDLE;
         done_ff   <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (dstate_ff)
            D_IDLE: if (start) dstate_ff <= D_CHK;
            D_CHK: begin
               if (vz_ff || num_ff <= 51'sd0 || num_ff[49:0] >= 50'({den_ff, 17'd0})) begin
                  done_ff   <= 1'b1;
                  dstate_ff <= D_IDLE;
               end else begin
                  dstate_ff <= D_DIV;
               end
            end
            D_DIV: if (cnt_ff == 5'd0) dstate_ff <= D_FIN;
            D_FIN: begin
               done_ff   <= 1'b1;
               dstate_ff <= D_IDLE;
            end
            default: dstate_ff <= D_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (dstate_ff)
         D_IDLE: begin
            num_ff <= prod;
            den_ff <= {vdc, 1'b0};
            vz_ff  <= (vdc == 31'd0);
            pos_ff <= (abc > 32'sd0);
            neg_ff <= abc[31];
         end
         D_CHK: begin
            rem_ff <= num_ff[49:0];
            dsh_ff <= 50'({den_ff, 16'd0});
            quo_ff <= '0;
            cnt_ff <= 5'd16;
            if (vz_ff) begin
               // no DC link: rail to the sign of the phase command, mid-period when it is zero
               if (pos_ff) duty_ff <= PWM_PERIOD_COUNT;
               else if (neg_ff) duty_ff <= 16'd0;
               else duty_ff <= PWM_PERIOD_COUNT >> 1;
            end else if (num_ff <= 51'sd0) begin
               duty_ff <= 16'd0;
            end else begin
               duty_ff <= PWM_PERIOD_COUNT;
            end
         end
         D_DIV: begin
            if (rem_ff >= dsh_ff) begin
               rem_ff <= rem_ff - dsh_ff;
               quo_ff <= {quo_ff[15:0], 1'b1};
            end else begin
               quo_ff <= {quo_ff[15:0], 1'b0};
            end
            dsh_ff <= dsh_ff >> 1;
            cnt_ff <= cnt_ff - 5'd1;
         end
         D_FIN: duty_ff <= (quo_ff > {1'b0, PWM_PERIOD_COUNT}) ? PWM_PERIOD_COUNT
                                                               : quo_ff[15:0];
         default: ;
      endcase
   end

   assign done = done_ff;
   assign duty = duty_ff;

endmodule
`default_nettype wire

/* sv/dcdq_datapath.sv */
// Datapath: configuration registers, request registers, integrators, one shared
// Q16.16 multiplier stepped by the sequencer, and the duty unit. Uses dcdq_pkg, dcdq_duty.
`timescale 1ns / 1ps
`default_nettype none
module dcdq_datapath
   import dcdq_pkg::*;
#(
   parameter logic [15:0] PWM_PERIOD_COUNT = PKG_PWM_PERIOD_COUNT,
   parameter logic [31:0] OMEGA_NOM_Q16    = PKG_OMEGA_NOM_Q16,
   parameter logic [31:0] VOLT_NOM_Q16     = PKG_VOLT_NOM_Q16,
   parameter logic [31:0] IND_FF_Q16       = PKG_IND_FF_Q16,
   parameter logic [31:0] OUT_CUR_FF_Q16   = PKG_OUT_CUR_FF_Q16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire cmd_type            cmd,
   output status_type              status,
   input  wire logic               csr_wr_en,
   input  wire logic [2:0]         csr_index,
   input  wire logic [30:0]        csr_wdata,
   input  wire logic               req_enable,
   input  wire logic signed [31:0] req_p_meas,
   input  wire logic signed [31:0] req_q_meas,
   input  wire logic signed [31:0] req_vc_d,
   input  wire logic signed [31:0] req_vc_q,
   input  wire logic signed [31:0] req_io_d,
   input  wire logic signed [31:0] req_io_q,
   input  wire logic signed [31:0] req_il_d,
   input  wire logic signed [31:0] req_il_q,
   input  wire logic [15:0]        req_theta,
   input  wire logic [30:0]        req_vdc,
   output logic [15:0]             rsp_duty_a,
   output logic [15:0]             rsp_duty_b,
   output logic [15:0]             rsp_duty_c,
   output logic signed [31:0]      rsp_omega_out,
   output logic signed [31:0]      rsp_vref_d,
   output logic signed [31:0]      rsp_iref_d,
   output logic signed [31:0]      rsp_iref_q,
   output logic signed [31:0]      rsp_vinv_d,
   output logic signed [31:0]      rsp_vinv_q
);

   // configuration
   logic [30:0] dp_ff, dq_ff, kpv_ff, kiv_ff, kpi_ff, kii_ff, lim_ff, fcap_ff;

   // captured request
   logic               en_ff;
   logic signed [31:0] p_ff, q_ff, vcd_ff, vcq_ff, iod_ff, ioq_ff, ild_ff, ilq_ff;
   logic [15:0]        th_ff;
   logic [30:0]        vdc_ff;

   // integrators and working registers
   logic signed [31:0] vi0_ff, vi1_ff, ci0_ff, ci1_ff;
   logic signed [31:0] omega_ff, vrd_ff, wc_ff, wl_ff, ffd_ff, ffq_ff;
   logic signed [31:0] errd_ff, errq_ff, ird_ff, irq_ff, vid_ff, viq_ff;
   logic signed [31:0] z2_ff, s_ff, c_ff, a_ff, b_ff, cc_ff, t1_ff, t2_ff;
   logic signed [65:0] prod_ff;
   logic [15:0]        da_ff, db_ff, dc_ff;

   logic signed [32:0] mul_a, mul_b, zs, zc;
   logic signed [31:0] m, lim, duty_abc;
   logic signed [33:0] half_sum;
   logic [15:0]        th_c, duty;
   logic               duty_done;

   assign m    = sat_prod(prod_ff);
   assign th_c = th_ff + 16'd16384;
   assign zs   = sin_z(th_ff);
   assign zc   = sin_z(th_c);
   assign lim  = {1'b0, lim_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         dp_ff <= '0; dq_ff <= '0; kpv_ff <= '0; kiv_ff <= '0;
         kpi_ff <= '0; kii_ff <= '0; lim_ff <= '0; fcap_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_DROOP_P: dp_ff   <= csr_wdata;
            CSR_DROOP_Q: dq_ff   <= csr_wdata;
            CSR_KP_V:    kpv_ff  <= csr_wdata;
            CSR_KI_V_DT: kiv_ff  <= csr_wdata;
            CSR_KP_I:    kpi_ff  <= csr_wdata;
            CSR_KI_I_DT: kii_ff  <= csr_wdata;
            CSR_CUR_LIM: lim_ff  <= csr_wdata;
            CSR_FCAP:    fcap_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         en_ff  <= req_enable;
         p_ff   <= req_p_meas;  q_ff   <= req_q_meas;
         vcd_ff <= req_vc_d;    vcq_ff <= req_vc_q;
         iod_ff <= req_io_d;    ioq_ff <= req_io_q;
         ild_ff <= req_il_d;    ilq_ff <= req_il_q;
         th_ff  <= req_theta;   vdc_ff <= req_vdc;
      end
   end

   // multiplier operand select per microstep
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.step)
         6'd0:  begin mul_a = sx33(p_ff);      mul_b = {2'b00, dp_ff}; end
         6'd1:  begin mul_a = sx33(q_ff);      mul_b = {2'b00, dq_ff}; end
         6'd2:  begin mul_a = sx33(omega_ff);  mul_b = {2'b00, fcap_ff}; end
         6'd3:  begin mul_a = sx33(iod_ff);    mul_b = {1'b0, OUT_CUR_FF_Q16}; end
         6'd4:  begin mul_a = sx33(wc_ff);     mul_b = sx33(vcq_ff); end
         6'd5:  begin mul_a = sx33(ioq_ff);    mul_b = {1'b0, OUT_CUR_FF_Q16}; end
         6'd6:  begin mul_a = sx33(wc_ff);     mul_b = sx33(vcd_ff); end
         6'd7:  begin mul_a = {2'b00, kiv_ff}; mul_b = sx33(errd_ff); end
         6'd8:  begin mul_a = {2'b00, kpv_ff}; mul_b = sx33(errd_ff); end
         6'd9:  begin mul_a = {2'b00, kiv_ff}; mul_b = sx33(errq_ff); end
         6'd10: begin mul_a = {2'b00, kpv_ff}; mul_b = sx33(errq_ff); end
         6'd12: begin mul_a = sx33(omega_ff);  mul_b = {1'b0, IND_FF_Q16}; end
         6'd14: begin mul_a = sx33(wl_ff);     mul_b = sx33(ilq_ff); end
         6'd15: begin mul_a = sx33(wl_ff);     mul_b = sx33(ild_ff); end
         6'd17: begin mul_a = {2'b00, kii_ff}; mul_b = sx33(errd_ff); end
         6'd18: begin mul_a = {2'b00, kpi_ff}; mul_b = sx33(errd_ff); end
         6'd19: begin mul_a = {2'b00, kii_ff}; mul_b = sx33(errq_ff); end
         6'd20: begin mul_a = {2'b00, kpi_ff}; mul_b = sx33(errq_ff); end
         6'd22: begin mul_a = zs;              mul_b = zs; end
         6'd23: begin mul_a = SIN_C;           mul_b = sx33(m); end
         6'd24: begin mul_a = SIN_B - sx33(m); mul_b = sx33(z2_ff); end
         6'd25: begin mul_a = SIN_A - sx33(m); mul_b = zs; end
         6'd26: begin mul_a = zc;              mul_b = zc; end
         6'd27: begin mul_a = SIN_C;           mul_b = sx33(m); end
         6'd28: begin mul_a = SIN_B - sx33(m); mul_b = sx33(z2_ff); end
         6'd29: begin mul_a = SIN_A - sx33(m); mul_b = zc; end
         6'd31: begin mul_a = sx33(vid_ff);    mul_b = sx33(s_ff); end
         6'd32: begin mul_a = sx33(viq_ff);    mul_b = sx33(c_ff); end
         6'd33: begin mul_a = SQRT3_Q16;       mul_b = sx33(viq_ff); end
         6'd34: begin mul_a = SQRT3_Q16;       mul_b = sx33(vid_ff); end
         6'd35: begin mul_a = sx33(s_ff);      mul_b = sx33(t1_ff); end
         6'd36: begin mul_a = sx33(c_ff);      mul_b = sx33(t2_ff); end
         6'd37: begin mul_a = SQRT3_Q16;       mul_b = sx33(viq_ff); end
         6'd38: begin mul_a = SQRT3_Q16;       mul_b = sx33(vid_ff); end
         6'd39: begin mul_a = sx33(s_ff);      mul_b = sx33(t1_ff); end
         6'd40: begin mul_a = sx33(c_ff);      mul_b = sx33(t2_ff); end
         default: ;
      endcase
   end

   // floor halving of the two-product sum for phases b and c
   always_comb begin
      if (cmd.step == 6'd37)
         half_sum = $signed({b_ff[31], b_ff[31], b_ff} + {m[31], m[31], m}) >>> 1;
      else
         half_sum = $signed({cc_ff[31], cc_ff[31], cc_ff} + {m[31], m[31], m}) >>> 1;
   end

   always_ff @(posedge clock) begin
      if (cmd.step_en) begin
         prod_ff <= mul_a * mul_b;
         case (cmd.step)
            6'd1:  omega_ff <= en_ff ? sadd({1'b0, OMEGA_NOM_Q16}, neg33(m)) : OMEGA_NOM_Q16;
            6'd2:  vrd_ff   <= en_ff ? sadd({1'b0, VOLT_NOM_Q16}, neg33(m)) : VOLT_NOM_Q16;
            6'd3:  wc_ff    <= m;
            6'd4:  ffd_ff   <= m;
            6'd5: begin
               ffd_ff  <= sadd(sx33(ffd_ff), neg33(m));
               errd_ff <= sadd(sx33(vrd_ff), neg33(vcd_ff));
               errq_ff <= sadd(neg33(vcq_ff), '0);
            end
            6'd6:  ffq_ff <= m;
            6'd7:  ffq_ff <= sadd(sx33(ffq_ff), sx33(m));
            6'd9:  ird_ff <= sadd(sx33(m), sx33(vi0_ff));
            6'd11: begin
               irq_ff <= sadd(sx33(m), sx33(vi1_ff));
               ird_ff <= sadd(sx33(ird_ff), sx33(ffd_ff));
            end
            6'd12: irq_ff <= sadd(sx33(irq_ff), sx33(ffq_ff));
            6'd13: begin
               wl_ff <= m;
               if (ird_ff > lim) ird_ff <= lim;
               else if (ird_ff < -lim) ird_ff <= -lim;
               if (irq_ff > lim) irq_ff <= lim;
               else if (irq_ff < -lim) irq_ff <= -lim;
            end
            6'd15: ffd_ff <= sadd(sx33(vcd_ff), neg33(m));
            6'd16: begin
               ffq_ff  <= sadd(sx33(vcq_ff), sx33(m));
               errd_ff <= sadd(sx33(ird_ff), neg33(ild_ff));
               errq_ff <= sadd(sx33(irq_ff), neg33(ilq_ff));
            end
            6'd19: vid_ff <= sadd(sx33(m), sx33(ci0_ff));
            6'd21: begin
               viq_ff <= sadd(sx33(m), sx33(ci1_ff));
               vid_ff <= sadd(sx33(vid_ff), sx33(ffd_ff));
            end
            6'd22: viq_ff <= sadd(sx33(viq_ff), sx33(ffq_ff));
            6'd23: z2_ff  <= m;
            6'd26: s_ff   <= sin_cap(m, th_ff[15]);
            6'd27: z2_ff  <= m;
            6'd30: c_ff   <= sin_cap(m, th_c[15]);
            6'd32: a_ff   <= m;
            6'd33: a_ff   <= sadd(sx33(a_ff), sx33(m));
            6'd34: t1_ff  <= sadd(neg33(vid_ff), sx33(m));
            6'd35: t2_ff  <= sadd(neg33(m), neg33(viq_ff));
            6'd36: b_ff   <= m;
            6'd37: b_ff   <= sat34(half_sum);
            6'd38: t1_ff  <= sadd(neg33(vid_ff), neg33(m));
            6'd39: t2_ff  <= sadd(sx33(m), neg33(viq_ff));
            6'd40: cc_ff  <= m;
            6'd41: cc_ff  <= sat34(half_sum);
            default: ;
         endcase
      end
   end

   // integrator state; cleared after use when the request has enable low
   always_ff @(posedge clock) begin
      if (reset) begin
         vi0_ff <= '0; vi1_ff <= '0; ci0_ff <= '0; ci1_ff <= '0;
      end else if (cmd.step_en) begin
         case (cmd.step)
            6'd8:  vi0_ff <= sadd(sx33(vi0_ff), sx33(m));
            6'd10: vi1_ff <= sadd(sx33(vi1_ff), sx33(m));
            6'd11: if (!en_ff) begin vi0_ff <= '0; vi1_ff <= '0; end
            6'd18: ci0_ff <= sadd(sx33(ci0_ff), sx33(m));
            6'd20: ci1_ff <= sadd(sx33(ci1_ff), sx33(m));
            6'd21: if (!en_ff) begin ci0_ff <= '0; ci1_ff <= '0; end
            default: ;
         endcase
      end
   end

   always_comb begin
      case (cmd.phase)
         PH_A:    duty_abc = a_ff;
         PH_B:    duty_abc = b_ff;
         default: duty_abc = cc_ff;
      endcase
   end

   dcdq_duty #(
      .PWM_PERIOD_COUNT(PWM_PERIOD_COUNT)
   ) u_duty (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .abc   (duty_abc),
      .vdc   (vdc_ff),
      .done  (duty_done),
      .duty  (duty)
   );

   assign status.div_done = duty_done;

   always_ff @(posedge clock) begin
      if (duty_done) begin
         case (cmd.phase)
            PH_A:    da_ff <= duty;
            PH_B:    db_ff <= duty;
            default: dc_ff <= duty;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_duty_a    <= da_ff;
         rsp_duty_b    <= db_ff;
         rsp_duty_c    <= dc_ff;
         rsp_omega_out <= omega_ff;
         rsp_vref_d    <= vrd_ff;
         rsp_iref_d    <= ird_ff;
         rsp_iref_q    <= irq_ff;
         rsp_vinv_d    <= vid_ff;
         rsp_vinv_q    <= viq_ff;
      end
   end

endmodule
`default_nettype wire

/* sv/dcdq_checker.sv */
// Port-level checks for the droop dq controller, bound to the top level.
// Uses dcdq_pkg for the default PWM period.
`timescale 1ns / 1ps
`default_nettype none
module dcdq_checker
   import dcdq_pkg::*;
#(
   parameter logic [15:0] PWM_PERIOD_COUNT = PKG_PWM_PERIOD_COUNT
) (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [15:0] rsp_duty_a,
   input wire logic [15:0] rsp_duty_b,
   input wire logic [15:0] rsp_duty_c
);

   // a parked result stays valid, with duty_a stable, until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_duty_a))
      else $error("result dropped or changed while stalled");

   // duties never exceed the PWM period
   a_duty_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_duty_a <= PWM_PERIOD_COUNT && rsp_duty_b <= PWM_PERIOD_COUNT
                    && rsp_duty_c <= PWM_PERIOD_COUNT)
      else $error("duty above PWM period");

   // one request in flight: busy right after acceptance
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   a_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid out of reset");

endmodule

bind droop_cascaded_dq_inverter_control dcdq_checker #(
   .PWM_PERIOD_COUNT(PWM_PERIOD_COUNT)
) u_dcdq_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_valid),
   .req_ready  (req_ready),
   .rsp_valid  (rsp_valid),
   .rsp_ready  (rsp_ready),
   .rsp_duty_a (rsp_duty_a),
   .rsp_duty_b (rsp_duty_b),
   .rsp_duty_c (rsp_duty_c)
);
`default_nettype wire

/* test/droop_cascaded_dq_inverter_control_tb.sv */
// Testbench for the droop inverter controller with cascaded dq PI loops.
// Depends on dcdq_pkg and droop_cascaded_dq_inverter_control; self-checking against
// an in-bench fixed-point predictor, with random request and response stalls.
`timescale 1ns / 1ps
`default_nettype none
module droop_cascaded_dq_inverter_control_tb;
   import dcdq_pkg::*;

   typedef struct packed {
      logic        enable;
      logic [31:0] p_meas, q_meas, vc_d, vc_q, io_d, io_q, il_d, il_q;
      logic [15:0] theta;
      logic [30:0] vdc;
   } ctl_req_t;

   typedef struct packed {
      logic [15:0] duty_a, duty_b, duty_c;
      logic [31:0] omega_out, vref_d, iref_d, iref_q, vinv_d, vinv_q;
   } ctl_rsp_t;

   logic clock = 0, reset = 1;
   logic csr_wr_en = 0;
   logic [2:0] csr_index = CSR_DROOP_P;
   logic [30:0] csr_wdata = '0;
   logic req_valid = 0, req_ready, rsp_valid, rsp_ready = 0;
   ctl_req_t req_cur = '0;
   ctl_rsp_t got;

   droop_cascaded_dq_inverter_control dut (
      .clock, .reset, .csr_wr_en, .csr_index, .csr_wdata,
      .req_valid, .req_ready,
      .req_enable(req_cur.enable), .req_p_meas(req_cur.p_meas),
      .req_q_meas(req_cur.q_meas), .req_vc_d(req_cur.vc_d), .req_vc_q(req_cur.vc_q),
      .req_io_d(req_cur.io_d), .req_io_q(req_cur.io_q), .req_il_d(req_cur.il_d),
      .req_il_q(req_cur.il_q), .req_theta(req_cur.theta), .req_vdc(req_cur.vdc),
      .rsp_valid, .rsp_ready,
      .rsp_duty_a(got.duty_a), .rsp_duty_b(got.duty_b), .rsp_duty_c(got.duty_c),
      .rsp_omega_out(got.omega_out), .rsp_vref_d(got.vref_d),
      .rsp_iref_d(got.iref_d), .rsp_iref_q(got.iref_q),
      .rsp_vinv_d(got.vinv_d), .rsp_vinv_q(got.vinv_q)
   );

   always #6 clock = ~clock;

   // predictor state
   longint unsigned gain [8];
   longint vint [2], cint [2];

   ctl_req_t pending_reqs [$];
   ctl_rsp_t expected_rsps [$];
   int n_err = 0, n_rsp = 0, n_sent = 0, idle_cnt = 0;
   bit quiet = 0, stim_done = 0;
   bit req_taken = 0;

   function automatic longint clip32(longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
   endfunction

   // >>> on longint is arithmetic, i.e. floor
   function automatic longint qmul(longint a, longint b);
      return clip32((a * b) >>> 16);
   endfunction

   function automatic longint sine_q16(int unsigned th);
      int unsigned t16, quad;
      longint z, z2, t;
      t16 = th & 16'hFFFF;
      quad = t16 >> 14;
      z = (t16 & 16'h3FFF) << 2;
      if (quad & 1) z = 65536 - z;
      z2 = (z * z) >>> 16;
      t = (4640 * z2) >>> 16;
      t = 42047 - t;
      t = (t * z2) >>> 16;
      t = 102944 - t;
      t = (t * z) >>> 16;
      if (t > 65536) t = 65536;
      return (quad & 2) ? -t : t;
   endfunction

   function automatic logic [15:0] duty_count(longint abc, longint vdc);
      longint p, num, q;
      p = PKG_PWM_PERIOD_COUNT;
      if (vdc == 0) return abc > 0 ? p[15:0] : (abc < 0 ? 16'd0 : 16'(p / 2));
      num = 2 * abc * p + vdc * p;
      if (num <= 0) return 16'd0;
      q = num / (2 * vdc);
      if (q > p) q = p;
      return q[15:0];
   endfunction

   function automatic longint pi_update(inout longint integ, input longint err,
                                        input longint kp, input longint ki);
      integ = clip32(integ + qmul(ki, err));
      return clip32(qmul(kp, err) + integ);
   endfunction

   function automatic ctl_rsp_t predict_control(ctl_req_t r);
      ctl_rsp_t o;
      longint p, q, vcd, vcq, iod, ioq, ild, ilq, vdc;
      longint omega, vrd, wc, wl, ffd, ffq, ird, irq, vid, viq, lim;
      longint s, c, t1, t2, a, b, cc;
      p = longint'(signed'(r.p_meas)); q = longint'(signed'(r.q_meas));
      vcd = longint'(signed'(r.vc_d)); vcq = longint'(signed'(r.vc_q));
      iod = longint'(signed'(r.io_d)); ioq = longint'(signed'(r.io_q));
      ild = longint'(signed'(r.il_d)); ilq = longint'(signed'(r.il_q));
      vdc = r.vdc;
      if (r.enable) begin
         omega = clip32(PKG_OMEGA_NOM_Q16 - qmul(gain[CSR_DROOP_P], p));
         vrd = clip32(PKG_VOLT_NOM_Q16 - qmul(gain[CSR_DROOP_Q], q));
      end else begin
         omega = PKG_OMEGA_NOM_Q16;
         vrd = PKG_VOLT_NOM_Q16;
      end
      wc = qmul(omega, gain[CSR_FCAP]);
      ffd = clip32(qmul(iod, PKG_OUT_CUR_FF_Q16) - qmul(wc, vcq));
      ffq = clip32(qmul(ioq, PKG_OUT_CUR_FF_Q16) + qmul(wc, vcd));
      ird = pi_update(vint[0], clip32(vrd - vcd), gain[CSR_KP_V], gain[CSR_KI_V_DT]);
      irq = pi_update(vint[1], clip32(-vcq), gain[CSR_KP_V], gain[CSR_KI_V_DT]);
      if (!r.enable) begin vint[0] = 0; vint[1] = 0; end
      ird = clip32(ird + ffd);
      irq = clip32(irq + ffq);
      lim = gain[CSR_CUR_LIM];
      if (ird > lim) ird = lim;
      if (ird < -lim) ird = -lim;
      if (irq > lim) irq = lim;
      if (irq < -lim) irq = -lim;
      wl = qmul(omega, PKG_IND_FF_Q16);
      ffd = clip32(vcd - qmul(wl, ilq));
      ffq = clip32(vcq + qmul(wl, ild));
      vid = pi_update(cint[0], clip32(ird - ild), gain[CSR_KP_I], gain[CSR_KI_I_DT]);
      viq = pi_update(cint[1], clip32(irq - ilq), gain[CSR_KP_I], gain[CSR_KI_I_DT]);
      if (!r.enable) begin cint[0] = 0; cint[1] = 0; end
      vid = clip32(vid + ffd);
      viq = clip32(viq + ffq);
      s = sine_q16(r.theta);
      c = sine_q16(r.theta + 16384);
      a = clip32(qmul(vid, s) + qmul(viq, c));
      t1 = clip32(-vid + qmul(113512, viq));
      t2 = clip32(-qmul(113512, vid) - viq);
      b = clip32((qmul(s, t1) + qmul(c, t2)) >>> 1);
      t1 = clip32(-vid - qmul(113512, viq));
      t2 = clip32(qmul(113512, vid) - viq);
      cc = clip32((qmul(s, t1) + qmul(c, t2)) >>> 1);
      o.duty_a = duty_count(a, vdc);
      o.duty_b = duty_count(b, vdc);
      o.duty_c = duty_count(cc, vdc);
      o.omega_out = omega[31:0]; o.vref_d = vrd[31:0];
      o.iref_d = ird[31:0]; o.iref_q = irq[31:0];
      o.vinv_d = vid[31:0]; o.vinv_q = viq[31:0];
      return o;
   endfunction

   // acceptance is seen at the rising edge, acted on at the next falling edge
   always @(posedge clock) req_taken <= !reset && req_valid && req_ready;

   // request driver: predicts at acceptance so config stays in step
   always @(negedge clock) begin
      if (!reset) begin
         if (req_taken) begin
            expected_rsps.push_back(predict_control(req_cur));
            n_sent++;
         end
         if (!req_valid || req_taken) begin
            if (pending_reqs.size() > 0 && (quiet || $urandom_range(99) >= 32)) begin
               req_cur <= pending_reqs.pop_front();
               req_valid <= 1;
            end else
               req_valid <= 0;
         end
         rsp_ready <= quiet || $urandom_range(99) >= 32;
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         n_rsp++;
         if (expected_rsps.size() == 0) begin
            n_err++;
            if (n_err <= 10) $display("unexpected response %p", got);
         end else begin
            ctl_rsp_t e;
            e = expected_rsps.pop_front();
            if (e !== got) begin
               n_err++;
               if (n_err <= 10) $display("mismatch: exp %p got %p", e, got);
            end
         end
      end
   end

   // watchdog on lack of handshake progress
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset)
         idle_cnt <= 0;
      else
         idle_cnt <= idle_cnt + 1;
      if (idle_cnt > 5000) begin
         $display("tb: failure");
         $finish;
      end
   end

   function automatic logic [31:0] rand_field(int kind);
      case (kind)
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'(signed'($urandom_range(131072)) - 65536);
         3: return 32'(signed'($urandom_range(3276800)) - 1638400);
         default: return $urandom;
      endcase
   endfunction

   function automatic ctl_req_t rand_req();
      ctl_req_t r;
      r.enable = $urandom_range(9) != 0;
      r.p_meas = rand_field($urandom_range(12)); r.q_meas = rand_field($urandom_range(12));
      r.vc_d = rand_field($urandom_range(12)); r.vc_q = rand_field($urandom_range(12));
      r.io_d = rand_field($urandom_range(12)); r.io_q = rand_field($urandom_range(12));
      r.il_d = rand_field($urandom_range(12)); r.il_q = rand_field($urandom_range(12));
      r.theta = 16'($urandom);
      case ($urandom_range(9))
         0: r.vdc = 31'd0;
         1: r.vdc = 31'h7FFF_FFFF;
         2: r.vdc = 31'($urandom_range(655360));
         default: r.vdc = 31'($urandom_range(400) * 65536 + $urandom_range(65535));
      endcase
      return r;
   endfunction

   task automatic drain();
      while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (150) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [30:0] val);
      @(negedge clock);
      csr_wr_en <= 1; csr_index <= idx; csr_wdata <= val;
      gain[idx] = val;
      @(negedge clock);
      csr_wr_en <= 0;
   endtask

   task automatic load_gains(int mode);
      for (int i = 0; i < 8; i++) begin
         logic [30:0] v;
         case (mode)
            0: v = '0;
            1: v = 31'h7FFF_FFFF;
            2: v = (i == CSR_CUR_LIM) ? 31'd1310720 : 31'($urandom_range(131072));
            default: v = 31'($urandom);
         endcase
         write_reg(3'(i), v);
      end
   endtask

   initial begin
      ctl_req_t r;
      for (int i = 0; i < 8; i++) gain[i] = 0;
      vint = '{0, 0}; cint = '{0, 0};
      repeat (2) @(posedge clock);
      @(negedge clock) reset <= 0;
      // directed: realistic gains, then field extremes, theta quadrants, vdc zero
      load_gains(2);
      for (int k = 0; k < 20; k++) begin
         r = rand_req();
         r.theta = 16'(k * 8192 + (k > 8 ? 16'hFFFF : 0));
         r.enable = (k % 5) != 4;
         if (k < 4) begin
            r.p_meas = k[0] ? 32'h7FFF_FFFF : 32'h8000_0000;
            r.vc_d = k[1] ? 32'h7FFF_FFFF : 32'h8000_0000;
            r.il_q = ~r.vc_d;
            r.vdc = k[0] ? 31'd0 : 31'h7FFF_FFFF;
         end
         pending_reqs.push_back(r);
      end
      drain();
      // random phases over several gain settings, incl. all zero and all max
      for (int ph = 0; ph < 6; ph++) begin
         load_gains(ph == 0 ? 0 : ph == 1 ? 1 : ph < 4 ? 2 : 3);
         quiet = (ph == 2);
         for (int k = 0; k < 125; k++) pending_reqs.push_back(rand_req());
         drain();
      end
      $display("covered %0d requests over 7 gain settings, %0d responses checked",
               n_sent, n_rsp);
      if (n_err == 0 && expected_rsps.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end
endmodule
`default_nettype wire
